// File: hw/rtl/dlef_pkg.sv
// Shared constants, types and the gamma table of the diagonal Laplacian edge filter.
package dlef_pkg;

    // Default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // Pixel and result field widths
    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    // Smallest frame dimension
    localparam int MIN_DIM = 3;

    // floor(sum/3) == (sum*683) >> 11 for every sum of three 8-bit channels
    localparam int GRAY_SUM_W  = 10;
    localparam int GRAY_RECIP  = 683;
    localparam int GRAY_SHIFT  = 11;
    localparam int GRAY_PROD_W = 20;

    // Signed width of 4*c - four neighbors
    localparam int LAP_W = 12;

    // Pixel info carried from the front end down the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_column;
        logic             interior;
        logic             last;
    } pix_info_t;

    // Gamma table: entry v is the largest k with k^4 <= v*255^3
    typedef logic [PIX_W-1:0] gamma_rom_t [256];

    function automatic gamma_rom_t gamma_build();
        gamma_rom_t      rom;
        longint unsigned limit;
        longint unsigned t;
        logic [7:0]      k;
        for (int v = 0; v < 256; v++)
        begin
            limit = 64'(v) * 64'd16581375;
            k     = '0;
            for (int b = 7; b >= 0; b--)
            begin
                t = 64'(k | (8'd1 << b));
                if (t * t * t * t <= limit)
                begin
                    k[b] = 1'b1;
                end
            end
            rom[v] = k;
        end
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = gamma_build();

endpackage

// File: hw/rtl/dlef_pix_if.sv
// Input channel: one RGB pixel item per handshake.
interface dlef_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hw/rtl/dlef_res_if.sv
// Output channel: one edge result item per handshake.
interface dlef_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  edge_value;
    logic [11:0] center_row;
    logic [9:0]  center_column;
    logic        last_of_frame;

    modport source (output valid, output edge_value, output center_row,
                    output center_column, output last_of_frame, input ready);
    modport sink   (input valid, input edge_value, input center_row,
                    input center_column, input last_of_frame, output ready);
endinterface

// File: hw/rtl/dlef_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module dlef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dlef_ctrl.sv
// Front end: config registers, raster counters, gray conversion and first pipeline stage.
module dlef_ctrl #(
    parameter int MAX_WIDTH = dlef_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dlef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlef_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  logic                                advance,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]        s1_addr,
    output dlef_pkg::pix_info_t                 s1_info,
    output logic                                s1_valid
);
    import dlef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = ((WW > IMG_W_W) ? WW : IMG_W_W) + 1;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [CW-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               s1_valid_reg;
    pix_info_t          s1_info_reg, s1_info_next;
    logic [CW-1:0]      s1_addr_reg;

    logic [EW-1:0]      w_ext;
    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [CW-1:0]      col_c;
    logic [ROW_W:0]     row_t;
    logic [ROW_W-1:0]   row_c;
    logic [WW-1:0]      col_inc;
    logic [ROW_W:0]     row_inc;
    logic [GRAY_SUM_W-1:0]  gray_sum;
    logic [GRAY_PROD_W-1:0] gray_prod;

    // Saturate the configured frame size
    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(MIN_DIM))
        begin
            w_eff = WW'(MIN_DIM);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_ext);
        end
        h_eff = (height_reg < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : height_reg;
    end

    // Position of the incoming pixel and the counters after it
    always_comb
    begin
        if (WW'(col_reg) >= w_eff)
        begin
            col_c = '0;
            row_t = {1'b0, row_reg} + 1'b1;
        end
        else
        begin
            col_c = col_reg;
            row_t = {1'b0, row_reg};
        end
        row_c = (row_t >= {1'b0, h_eff}) ? '0 : row_t[ROW_W-1:0];

        col_inc = WW'(col_c) + 1'b1;
        row_inc = {1'b0, row_c} + 1'b1;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_c + 1'b1;
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = row_c;
        end
    end

    // Gray = floor((r+g+b)/3) by reciprocal multiply
    always_comb
    begin
        gray_sum  = GRAY_SUM_W'(red) + GRAY_SUM_W'(green) + GRAY_SUM_W'(blue);
        gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);
        s1_info_next.gray          = gray_prod[GRAY_SHIFT +: PIX_W];
        s1_info_next.center_row    = row_c - 1'b1;
        s1_info_next.center_column = COL_W'(col_c - 1'b1);
        s1_info_next.interior      = (row_c >= ROW_W'(2)) && (col_c >= CW'(2));
        s1_info_next.last          = (row_c == h_eff - 1'b1) && (WW'(col_c) == w_eff - 1'b1);
    end

    // Config, counters and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= IMAGE_WIDTH_RST;
            height_reg   <= IMAGE_HEIGHT_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= s1_info_next;
            s1_addr_reg <= col_c;
        end
    end

    assign rd_addr  = col_c;
    assign s1_addr  = s1_addr_reg;
    assign s1_info  = s1_info_reg;
    assign s1_valid = s1_valid_reg;

endmodule

// File: hw/rtl/dlef_window.sv
// 3x3 window of gray pixels and the clamped diagonal Laplacian of its center.
module dlef_window (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] upper,
    input  logic [7:0] middle,
    input  logic [7:0] gray,
    output logic [7:0] lap_clamped
);
    import dlef_pkg::*;

    // Only the taps that feed the kernel: top row cols 1..2, center, bottom cols 1..2
    logic [PIX_W-1:0] top1_reg, top2_reg, mid2_reg, bot1_reg, bot2_reg;
    logic signed [LAP_W-1:0] lap;

    // After the shift: corners are old top1, new upper, old bot1, new gray; center old mid2
    always_comb
    begin
        lap = $signed({2'b00, mid2_reg, 2'b00})
            - $signed(LAP_W'(top1_reg)) - $signed(LAP_W'(upper))
            - $signed(LAP_W'(bot1_reg)) - $signed(LAP_W'(gray));
        if (lap < 0)
        begin
            lap_clamped = '0;
        end
        else if (lap > LAP_W'(255))
        begin
            lap_clamped = 8'hFF;
        end
        else
        begin
            lap_clamped = lap[PIX_W-1:0];
        end
    end

    // Shift the window one column left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top1_reg <= '0;
            top2_reg <= '0;
            mid2_reg <= '0;
            bot1_reg <= '0;
            bot2_reg <= '0;
        end
        else if (step)
        begin
            top1_reg <= top2_reg;
            top2_reg <= upper;
            mid2_reg <= middle;
            bot1_reg <= bot2_reg;
            bot2_reg <= gray;
        end
    end

endmodule

// File: hw/rtl/diagonal_laplacian_edge_filter.sv
// Top level of the diagonal Laplacian edge filter.
//
// pix_in takes RGB pixels in raster order, one item per valid/ready handshake.
// res_out gives one item per interior pixel (not on the frame border): the
// gamma-mapped clamped value 4*center minus the four diagonal neighbors, with
// the center's row and column and a flag on the frame's last interior pixel.
// A result leaves on the item that brings the lower-right neighbor of its center.
// Frame size comes from the config port (cfg_we, cfg_index, cfg_data); write it
// only while the block is idle.
// Throughput: one pixel per cycle while res_out is not stalled. Path: line store
// read, kernel into stage 2, gamma table into the output register.
// The two line stores share one 16-bit RAM; each pixel reads and writes its
// column once, so the single read and write port sets the one-per-cycle rate.
// Reset returns the size registers to 640x480, the counters to the frame start
// and the window to zero; line store contents are not cleared.
// When res_out stalls with a result waiting, the whole pipeline holds and
// pix_in.ready drops until the result is taken.
module diagonal_laplacian_edge_filter #(
    parameter int MAX_WIDTH = dlef_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dlef_pix_if.sink                        pix_in,
    dlef_res_if.source                      res_out,
    input  logic                            cfg_we,
    input  logic [dlef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlef_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dlef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic              advance, accept;
    logic [CW-1:0]     rd_addr, s1_addr;
    pix_info_t         s1_info;
    logic              s1_valid;
    logic [2*PIX_W-1:0] line_rdata, line_wdata;
    logic [PIX_W-1:0]  lap_clamped;
    logic              line_we;

    logic              s2_valid_reg;
    logic [PIX_W-1:0]  s2_lap_reg;
    pix_info_t         s2_info_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  edge_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              last_reg;

    // Whole pipeline moves when the output register is free or being taken
    assign advance      = !out_valid_reg || res_out.ready;
    assign accept       = pix_in.valid && advance;
    assign pix_in.ready = advance;

    dlef_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .advance   (advance),
        .red       (pix_in.red),
        .green     (pix_in.green),
        .blue      (pix_in.blue),
        .rd_addr   (rd_addr),
        .s1_addr   (s1_addr),
        .s1_info   (s1_info),
        .s1_valid  (s1_valid)
    );

    // Line stores: upper in the high byte, middle in the low byte; each row moves up
    assign line_we    = s1_valid && advance;
    assign line_wdata = {line_rdata[PIX_W-1:0], s1_info.gray};

    dlef_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (line_rdata)
    );

    dlef_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (line_we),
        .upper       (line_rdata[2*PIX_W-1:PIX_W]),
        .middle      (line_rdata[PIX_W-1:0]),
        .gray        (s1_info.gray),
        .lap_clamped (lap_clamped)
    );

    // Stage 2 and output valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid && s1_info.interior;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 2 and output payload; gamma table lookup into the output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_lap_reg  <= lap_clamped;
            s2_info_reg <= s1_info;
            edge_reg    <= GAMMA_ROM[s2_lap_reg];
            row_reg     <= s2_info_reg.center_row;
            col_reg     <= s2_info_reg.center_column;
            last_reg    <= s2_info_reg.last;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.edge_value    = edge_reg;
    assign res_out.center_row    = row_reg;
    assign res_out.center_column = col_reg;
    assign res_out.last_of_frame = last_reg;

endmodule
